// ----- hdl/cobs_pkg.sv -----
// ----------------------------------------------------------------------------
// cobs_pkg
// Shared types and constants for the COBS frame encoder.
// ----------------------------------------------------------------------------
package cobs_pkg;

  localparam int MAX_BLOCK  = 254;
  localparam int ADDR_W     = 8;
  localparam int POS_W      = 9;

  localparam logic [7:0] CODE_FULL  = 8'hFF;
  localparam logic [7:0] CODE_EMPTY = 8'h01;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        packet_done;
  } result_t;

  // one encoded byte on its way to the packer
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       eop;
  } enc_byte_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } enc_state_t;

endpackage

// ----- hdl/cobs_block_ram.sv -----
// ----------------------------------------------------------------------------
// cobs_block_ram
// Block store for held nonzero bytes, one write and one registered read port.
// ----------------------------------------------------------------------------
module cobs_block_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [cobs_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [cobs_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import cobs_pkg::*;

  logic [7:0] mem [MAX_BLOCK];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/cobs_packer.sv -----
// ----------------------------------------------------------------------------
// cobs_packer
// Gathers encoded bytes into result words and holds them in an output register.
// ----------------------------------------------------------------------------
module cobs_packer #(
  parameter int OUT_LANES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  cobs_pkg::enc_byte_t byte_in,
  output logic                byte_ready,
  output logic                result_valid,
  input  logic                result_stall,
  output cobs_pkg::result_t   result
);
  import cobs_pkg::*;

  localparam int CW     = $clog2(OUT_LANES + 1);
  localparam int WORD_W = 8 * OUT_LANES;

  logic [WORD_W-1:0] asm_bytes, asm_bytes_next;
  logic [CW-1:0]     asm_cnt, asm_cnt_next;
  logic              asm_closed, asm_closed_next;
  logic              asm_last, asm_last_next;
  logic              asm_eop, asm_eop_next;
  logic              out_valid, out_valid_next;
  result_t           out_item, out_item_next;
  logic              take, move;

  assign byte_ready = !asm_closed;
  assign take       = byte_valid && !asm_closed;
  assign move       = asm_closed && (!out_valid || !result_stall);

  always_comb begin
    asm_bytes_next  = asm_bytes;
    asm_cnt_next    = asm_cnt;
    asm_closed_next = asm_closed;
    asm_last_next   = asm_last;
    asm_eop_next    = asm_eop;
    out_valid_next  = out_valid && result_stall;
    out_item_next   = out_item;
    if (take) begin
      for (int i = 0; i < OUT_LANES; i++) begin
        if (asm_cnt == CW'(i)) begin
          asm_bytes_next[i*8 +: 8] = byte_in.value;
        end
      end
      asm_cnt_next    = asm_cnt + 1'b1;
      asm_closed_next = (asm_cnt_next == CW'(OUT_LANES)) || byte_in.last;
      asm_last_next   = byte_in.last;
      asm_eop_next    = byte_in.eop;
    end else if (move) begin
      out_valid_next             = 1'b1;
      out_item_next.out_bytes    = 64'(asm_bytes);
      out_item_next.byte_count   = 4'(asm_cnt);
      out_item_next.run_last     = asm_last;
      out_item_next.packet_done  = asm_last && asm_eop;
      asm_bytes_next             = '0;
      asm_cnt_next               = '0;
      asm_closed_next            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_bytes  <= '0;
      asm_cnt    <= '0;
      asm_closed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      asm_bytes  <= asm_bytes_next;
      asm_cnt    <= asm_cnt_next;
      asm_closed <= asm_closed_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    asm_last <= asm_last_next;
    asm_eop  <= asm_eop_next;
    out_item <= out_item_next;
  end

  assign result_valid = out_valid;
  assign result       = out_item;

endmodule

// ----- hdl/cobs_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// cobs_frame_encoder
// COBS encoder: raw packet bytes in, packed encoded bytes out.
// ----------------------------------------------------------------------------
// Nonzero bytes are written to a 254-entry block store, one item per cycle
// while no flush runs, with no result. A zero byte, a full block or the
// packet end starts a flush: the sequencer then reads the store once per
// cycle while the packer takes bytes, and feeds the code byte, the held
// bytes and, when the packet ends on a zero, a trailing 0x01 to the packer.
// Input is held off until the flush loads its last encoded byte (up to 255).
// Words hold up to OUT_LANES bytes, the first in bits 7:0; unused lanes zero.
module cobs_frame_encoder #(
  parameter int OUT_LANES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cobs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output cobs_pkg::result_t result
);
  import cobs_pkg::*;

  enc_state_t        state, state_next;
  logic [ADDR_W-1:0] fill, fill_next;
  logic [7:0]        code, code_next;
  logic [7:0]        nbytes, nbytes_next;
  logic              extra, extra_next;
  logic              eop, eop_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  pos_m1;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  logic              s_valid, s_from_mem, s_last, s_eop;
  logic [7:0]        s_value;
  logic              load, ld_from_mem, ld_last;
  logic [7:0]        ld_value;
  logic              byte_ready, stage_take;
  enc_byte_t         pk_byte;

  assign stage_take = s_valid && byte_ready;
  assign pos_m1     = pos - 1'b1;
  assign rd_addr    = pos_m1[ADDR_W-1:0];
  assign item_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    code_next   = code;
    nbytes_next = nbytes;
    extra_next  = extra;
    eop_next    = eop;
    pos_next    = pos;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    load        = 1'b0;
    ld_from_mem = 1'b0;
    ld_last     = 1'b0;
    ld_value    = CODE_EMPTY;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          pos_next = '0;
          eop_next = item.end_of_packet;
          if (item.data_byte == BYTE_ZERO) begin
            code_next   = fill + 1'b1;
            nbytes_next = fill;
            extra_next  = item.end_of_packet;
            fill_next   = '0;
            state_next  = ST_SEND;
          end else begin
            wr_en = 1'b1;
            if (fill == ADDR_W'(MAX_BLOCK - 1)) begin
              code_next   = CODE_FULL;
              nbytes_next = 8'(MAX_BLOCK);
              extra_next  = 1'b0;
              fill_next   = '0;
              state_next  = ST_SEND;
            end else if (item.end_of_packet) begin
              code_next   = fill + 8'd2;
              nbytes_next = fill + 1'b1;
              extra_next  = 1'b0;
              fill_next   = '0;
              state_next  = ST_SEND;
            end else begin
              fill_next = fill + 1'b1;
            end
          end
        end
      end
      ST_SEND: begin
        if (!s_valid || stage_take) begin
          load = 1'b1;
          if (pos == '0) begin
            ld_value = code;
          end else if (pos <= {1'b0, nbytes}) begin
            ld_from_mem = 1'b1;
            rd_en       = 1'b1;
          end
          ld_last  = (pos == ({1'b0, nbytes} + POS_W'(extra)));
          pos_next = pos + 1'b1;
          if (ld_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      pos     <= '0;
      s_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      pos  <= pos_next;
      if (load) begin
        s_valid <= 1'b1;
      end else if (stage_take) begin
        s_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code   <= code_next;
    nbytes <= nbytes_next;
    extra  <= extra_next;
    eop    <= eop_next;
    if (load) begin
      s_from_mem <= ld_from_mem;
      s_value    <= ld_value;
      s_last     <= ld_last;
      s_eop      <= eop;
    end
  end

  assign pk_byte.value = s_from_mem ? rd_data : s_value;
  assign pk_byte.last  = s_last;
  assign pk_byte.eop   = s_eop;

  cobs_block_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill),
    .wr_data (item.data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cobs_packer #(
    .OUT_LANES (OUT_LANES)
  ) u_packer (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (s_valid),
    .byte_in      (pk_byte),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- hdl/cobs_chk.sv -----
// ----------------------------------------------------------------------------
// cobs_chk
// Port-level checks for the COBS frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cobs_chk #(
  parameter int OUT_LANES = 8
) (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input cobs_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input cobs_pkg::result_t result
);
  import cobs_pkg::*;

  // byte count within lane range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.byte_count != 4'd0) &&
                     (result.byte_count <= 4'(OUT_LANES)))
    else $error("byte_count out of range");

  // packet end only on the last transfer of an item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.packet_done |-> result.run_last)
    else $error("packet_done without run_last");

  // only the last transfer of an item may be short
  a_full_words: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.run_last |-> result.byte_count == 4'(OUT_LANES))
    else $error("short word before run end");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // stalled input holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("stalled input transfer changed");

endmodule

bind cobs_frame_encoder cobs_chk #(.OUT_LANES(OUT_LANES)) u_cobs_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- bench/cobs_frame_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// cobs_frame_encoder_tb
// Self-checking bench for the COBS frame encoder: packets of raw bytes go in,
// and every packed result word is checked against a byte-stuffing predictor
// kept in the bench, under random valid/stall idling and one long output
// hold-off.
// ----------------------------------------------------------------------------
module cobs_frame_encoder_tb;
  import cobs_pkg::*;

  localparam int OUT_LANES   = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 600000;

  typedef logic [7:0] byte_list_t[$];

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int errors = 0;

  // encoder state mirrored by the predictor
  logic [7:0] held_bytes [MAX_BLOCK];
  int         held = 0;
  logic [7:0] enc_bytes[$];
  result_t    expected_words[$];

  cobs_frame_encoder #(.OUT_LANES(OUT_LANES)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cobs_frame_encoder regression: fail");
      $finish;
    end
  end

  // output side: random stall, plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic void close_block(input logic [7:0] code);
    enc_bytes.push_back(code);
    for (int i = 0; i < held; i++) enc_bytes.push_back(held_bytes[i]);
    held = 0;
  endfunction

  // stuff one raw byte and queue the result words it causes
  function automatic void stuff_byte(input item_t it);
    bit      full_sent;
    result_t w;
    int      cnt;
    full_sent = 1'b0;
    enc_bytes.delete();
    if (held >= MAX_BLOCK) held = 0;
    if (it.data_byte == BYTE_ZERO) begin
      close_block(8'(held + 1));
    end else begin
      held_bytes[held] = it.data_byte;
      held++;
      if (held >= MAX_BLOCK) begin
        close_block(CODE_FULL);
        full_sent = 1'b1;
      end
    end
    if (it.end_of_packet) begin
      if (!full_sent) close_block(8'(held + 1));
      held = 0;
    end
    for (int b = 0; b < enc_bytes.size(); b += OUT_LANES) begin
      w = '0;
      cnt = enc_bytes.size() - b;
      if (cnt > OUT_LANES) cnt = OUT_LANES;
      for (int i = 0; i < cnt; i++) w.out_bytes[8*i +: 8] = enc_bytes[b + i];
      w.byte_count = 4'(cnt);
      w.run_last = (b + OUT_LANES >= enc_bytes.size());
      w.packet_done = w.run_last && it.end_of_packet;
      expected_words.push_back(w);
    end
  endfunction

  // transfers on both sides, seen at the same edge
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (item_valid && !item_stall) stuff_byte(item);
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result", result.out_bytes, 64'd0);
        end else begin
          want = expected_words.pop_front();
          if (result.out_bytes !== want.out_bytes)
            report_mismatch("out_bytes", result.out_bytes, want.out_bytes);
          if (result.byte_count !== want.byte_count)
            report_mismatch("byte_count", 64'(result.byte_count), 64'(want.byte_count));
          if (result.run_last !== want.run_last)
            report_mismatch("run_last", 64'(result.run_last), 64'(want.run_last));
          if (result.packet_done !== want.packet_done)
            report_mismatch("packet_done", 64'(result.packet_done),
                            64'(want.packet_done));
        end
      end
    end
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_packet(input byte_list_t bytes);
    item_t it;
    foreach (bytes[i]) begin
      it.data_byte = bytes[i];
      it.end_of_packet = (i == bytes.size() - 1);
      send_item(it);
    end
  endtask

  function automatic byte_list_t random_packet(input int len, input int zero_pct);
    byte_list_t bytes;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < zero_pct) bytes.push_back(BYTE_ZERO);
      else if ($urandom_range(9) == 0) bytes.push_back(8'hFF);
      else bytes.push_back(8'($urandom_range(1, 255)));
    end
    return bytes;
  endfunction

  task automatic test_directed();
    byte_list_t pkt;
    pkt = '{BYTE_ZERO};                          send_packet(pkt);
    pkt = '{8'h11};                              send_packet(pkt);
    pkt = '{8'hFF};                              send_packet(pkt);
    pkt = '{8'h01, BYTE_ZERO, 8'hFF, BYTE_ZERO, BYTE_ZERO};
    send_packet(pkt);
    pkt = '{BYTE_ZERO, 8'h80, 8'h7F};            send_packet(pkt);
    // seven bytes fill one word exactly, eight spill into a second
    pkt = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
    send_packet(pkt);
    pkt = '{8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F};
    send_packet(pkt);
  endtask

  task automatic test_full_blocks();
    byte_list_t pkt;
    // packet ends exactly on a full block
    pkt = random_packet(MAX_BLOCK, 0);
    send_packet(pkt);
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int n_items);
    byte_list_t pkt;
    int         sent;
    int         len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 14);
      pkt = random_packet(len, ($urandom_range(3) == 0) ? 0 : 30);
      send_packet(pkt);
      sent += len;
    end
  endtask

  // output held off while zero-heavy packets keep arriving
  task automatic test_output_hold();
    byte_list_t pkt;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_token++;
    for (int p = 0; p < 15; p++) begin
      pkt = random_packet($urandom_range(1, 6), 50);
      send_packet(pkt);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_blocks();
    test_random(33, 69, 40);
    test_random(69, 33, 40);
    test_random(0, 0, 40);
    test_output_hold();
    item_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("results missing", 64'(expected_words.size()), 64'd0);
    if (errors == 0) begin
      $display("cobs_frame_encoder regression: pass");
    end else begin
      $display("cobs_frame_encoder regression: fail");
    end
    $finish;
  end

endmodule
